// ===== design/quoted_word_splitter_core_defines.svh =====
// Assertion macros shared by the quoted word splitter RTL.
`ifndef QUOTED_WORD_SPLITTER_CORE_DEFINES_SVH
`define QUOTED_WORD_SPLITTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define QWS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define QWS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define QWS_ASSERT(label, clk, rst, prop, msg)
`define QWS_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== design/qws_pkg.sv =====
// Types and constants shared by the quoted word splitter modules.
package qws_pkg;

   localparam int DATA_W      = 8;
   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 4;
   localparam int OFFSET_W    = 11;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [DATA_W-1:0] CH_NUL       = 8'h00;
   localparam logic [DATA_W-1:0] CH_TAB       = 8'h09;
   localparam logic [DATA_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [DATA_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [DATA_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [DATA_W-1:0] CH_BACKSLASH = 8'h5C;

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_IN_ARG  = 2'd1,
      MODE_ESCAPE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BIG     = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE    = 2'd0,
      KIND_ARG_END = 2'd1,
      KIND_CMD_END = 2'd2
   } kind_type;

   // One result word.
   typedef struct packed {
      kind_type                kind;
      logic [DATA_W-1:0]       data_byte;
      logic [INDEX_W-1:0]      arg_index;
      logic [OFFSET_W-1:0]     store_offset;
      logic [COUNT_W-1:0]      arg_count;
      status_type              status;
   } result_type;

   // Queue entry. With pair set, the entry is an argument end followed by
   // the command end one store slot later; arg_count and status then
   // belong to the command end.
   typedef struct packed {
      logic       pair;
      result_type res;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } queue_write_type;

   typedef struct packed {
      logic      valid;
      logic      full;
      entry_type entry;
   } queue_head_type;

endpackage

// ===== design/qws_front.sv =====
// Front end: accepts command bytes and runs the quoting and escape rules.
`include "quoted_word_splitter_core_defines.svh"
module qws_front #(
   parameter int MAX_ARGS    = 16,
   parameter int STORE_BYTES = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [qws_pkg::DATA_W-1:0]    req_ch,
   input  logic                          queue_full,
   output logic                          req_stall,
   output qws_pkg::queue_write_type      queue_wr
);
   import qws_pkg::*;

   localparam int AW = $clog2(MAX_ARGS + 1);
   localparam int BW = $clog2(STORE_BYTES + 1);

   mode_type        mode_ff, mode_in;
   quote_type       quote_ff, quote_in, quote_cur, quote_hit;
   logic [AW-1:0]   args_ff, args_in;
   logic [BW-1:0]   bytes_ff, bytes_in;
   status_type      err_ff, err_in;
   logic            accept, blank, room, do_keep;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign blank     = (req_ch == CH_SPACE) || (req_ch == CH_TAB);
   assign room      = bytes_ff <= BW'(STORE_BYTES - 2);
   assign quote_hit = (req_ch == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BETWEEN;
         quote_ff <= QUOTE_NONE;
         args_ff  <= '0;
         bytes_ff <= '0;
         err_ff   <= STATUS_OK;
      end else begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         args_ff  <= args_in;
         bytes_ff <= bytes_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      quote_cur = quote_ff;
      args_in   = args_ff;
      bytes_in  = bytes_ff;
      err_in    = err_ff;
      do_keep   = 1'b0;
      queue_wr  = '0;
      queue_wr.entry.res.kind   = KIND_BYTE;
      queue_wr.entry.res.status = STATUS_OK;
      if (accept) begin
         if (req_ch == CH_NUL) begin
            queue_wr.push                   = 1'b1;
            queue_wr.entry.res.store_offset = OFFSET_W'(bytes_ff);
            queue_wr.entry.res.arg_count    = COUNT_W'(args_ff);
            queue_wr.entry.res.kind         = KIND_CMD_END;
            queue_wr.entry.res.status       = err_ff;
            if (err_ff == STATUS_OK) begin
               if (mode_ff == MODE_ESCAPE ||
                   (mode_ff == MODE_IN_ARG && quote_ff != QUOTE_NONE)) begin
                  queue_wr.entry.res.status = STATUS_INVALID;
               end else if (mode_ff == MODE_IN_ARG) begin
                  queue_wr.entry.pair          = 1'b1;
                  queue_wr.entry.res.kind      = KIND_ARG_END;
                  queue_wr.entry.res.arg_index = INDEX_W'(args_ff - AW'(1));
               end
            end
            mode_in  = MODE_BETWEEN;
            quote_in = QUOTE_NONE;
            args_in  = '0;
            bytes_in = '0;
            err_in   = STATUS_OK;
         end else if (err_ff == STATUS_OK) begin
            if (mode_ff == MODE_ESCAPE) begin
               mode_in = MODE_IN_ARG;
               do_keep = 1'b1;
            end else if (mode_ff == MODE_BETWEEN && blank) begin
               mode_in = MODE_BETWEEN;
            end else if (mode_ff == MODE_BETWEEN &&
                         (args_ff >= AW'(MAX_ARGS) || !room)) begin
               err_in = STATUS_BIG;
            end else begin
               if (mode_ff == MODE_BETWEEN) begin
                  quote_cur = QUOTE_NONE;
                  args_in   = args_ff + AW'(1);
               end
               mode_in  = MODE_IN_ARG;
               quote_in = quote_cur;
               if (quote_cur == QUOTE_NONE && blank) begin
                  queue_wr.push                   = 1'b1;
                  queue_wr.entry.res.kind         = KIND_ARG_END;
                  queue_wr.entry.res.arg_index    = INDEX_W'(args_in - AW'(1));
                  queue_wr.entry.res.store_offset = OFFSET_W'(bytes_ff);
                  bytes_in = bytes_ff + BW'(1);
                  mode_in  = MODE_BETWEEN;
               end else if (req_ch == CH_BACKSLASH && quote_cur != QUOTE_SINGLE) begin
                  mode_in = MODE_ESCAPE;
               end else if (req_ch == CH_SQUOTE || req_ch == CH_DQUOTE) begin
                  if (quote_cur == QUOTE_NONE) begin
                     quote_in = quote_hit;
                  end else if (quote_cur == quote_hit) begin
                     quote_in = QUOTE_NONE;
                  end else begin
                     do_keep = 1'b1;
                  end
               end else begin
                  do_keep = 1'b1;
               end
            end
            if (do_keep) begin
               if (!room) begin
                  err_in = STATUS_BIG;
               end else begin
                  queue_wr.push                   = 1'b1;
                  queue_wr.entry.res.kind         = KIND_BYTE;
                  queue_wr.entry.res.data_byte    = req_ch;
                  queue_wr.entry.res.arg_index    = INDEX_W'(args_in - AW'(1));
                  queue_wr.entry.res.store_offset = OFFSET_W'(bytes_ff);
                  bytes_in = bytes_ff + BW'(1);
               end
            end
         end
      end
   end

   `QWS_ASSERT(a_store_bound, clock, reset, bytes_ff <= BW'(STORE_BYTES), "store count overran")
   `QWS_ASSERT(a_args_bound, clock, reset, args_ff <= AW'(MAX_ARGS), "argument count overran")

endmodule

// ===== design/qws_queue.sv =====
// Short queue of result entries between the front and back ends.
`include "quoted_word_splitter_core_defines.svh"
module qws_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  qws_pkg::queue_write_type      queue_wr,
   input  logic                          pop,
   output qws_pkg::queue_head_type       head
);
   import qws_pkg::*;

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]    count_ff, count_in;

   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         mem_ff[wr_ptr_ff] <= queue_wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(queue_wr.push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + (QUEUE_PTR_W + 1)'(queue_wr.push)
                  - (QUEUE_PTR_W + 1)'(pop);
   end

   assign head.valid = count_ff != '0;
   assign head.full  = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign head.entry = mem_ff[rd_ptr_ff];

   `QWS_NEVER(a_no_push_full, clock, reset, queue_wr.push && head.full, "push into full queue")
   `QWS_NEVER(a_no_pop_empty, clock, reset, pop && !head.valid, "pop from empty queue")

endmodule

// ===== design/qws_back.sv =====
// Back end: turns queue entries into result words in an output register.
`include "quoted_word_splitter_core_defines.svh"
module qws_back (
   input  logic                          clock,
   input  logic                          reset,
   input  qws_pkg::queue_head_type       head,
   output logic                          pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output qws_pkg::result_type           rsp_word
);
   import qws_pkg::*;

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   result_type  out_ff, out_in;
   logic        load;

   assign load = head.valid && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_comb begin
      out_in   = out_ff;
      phase_in = phase_ff;
      pop      = 1'b0;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         out_in   = head.entry.res;
         if (head.entry.pair && !phase_ff) begin
            // Argument end first; the command end follows from the same entry.
            out_in.arg_count = '0;
            out_in.status    = STATUS_OK;
            phase_in         = 1'b1;
         end else begin
            if (head.entry.pair) begin
               out_in.kind         = KIND_CMD_END;
               out_in.arg_index    = '0;
               out_in.store_offset = head.entry.res.store_offset + OFFSET_W'(1);
            end
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = out_ff;

   `QWS_ASSERT(a_phase_holds_end, clock, reset, phase_ff |-> (valid_ff && out_ff.kind == KIND_ARG_END), "pair phase without argument end")

endmodule

// ===== design/quoted_word_splitter_core.sv =====
// Top level of the quoted word splitter: front end, queue and back end.
//
// The block splits a command line into arguments. Each request word on
// req_ch is one byte; byte 0 ends the command. Spaces and tabs outside
// quotes separate arguments, single and double quotes group text, and a
// backslash outside single quotes makes the next byte literal.
// Each kept byte comes out as a response word of kind 0 with its argument
// index and store offset; each argument end as kind 1; the command end as
// kind 2 with the argument count and a status (ok, too big, invalid).
// After an error, bytes are dropped until byte 0.
// A request word is taken in a cycle in which it is offered and req_stall is
// low; its result passes through the queue and then the output register before
// it shows on the rsp_ ports. One word per cycle is sustained while rsp_stall
// stays low; byte 0 closing an open argument gives two response words from one
// queue entry, which the four-entry queue absorbs. When the receiver raises
// rsp_stall the response word holds; the queue fills and req_stall rises only
// once all four entries are taken.
// Synchronous reset clears all control state and the queue; the block is
// ready for a new command in the cycle after reset falls.
module quoted_word_splitter_core #(
   parameter int MAX_ARGS    = 16,
   parameter int STORE_BYTES = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [qws_pkg::DATA_W-1:0]     req_ch,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [qws_pkg::KIND_W-1:0]     rsp_kind,
   output logic [qws_pkg::DATA_W-1:0]     rsp_data_byte,
   output logic [qws_pkg::INDEX_W-1:0]    rsp_arg_index,
   output logic [qws_pkg::OFFSET_W-1:0]   rsp_store_offset,
   output logic [qws_pkg::COUNT_W-1:0]    rsp_arg_count,
   output logic [qws_pkg::STATUS_W-1:0]   rsp_status
);
   import qws_pkg::*;

   // Front end writes entries, back end drains them.
   queue_write_type  queue_wr;
   queue_head_type   head;
   logic             pop;
   result_type       rsp_word;

   qws_front #(
      .MAX_ARGS    (MAX_ARGS),
      .STORE_BYTES (STORE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ch     (req_ch),
      .queue_full (head.full),
      .req_stall  (req_stall),
      .queue_wr   (queue_wr)
   );

   qws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .head     (head)
   );

   qws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // The response word is unpacked onto one port per field.
   assign rsp_kind         = rsp_word.kind;
   assign rsp_data_byte    = rsp_word.data_byte;
   assign rsp_arg_index    = rsp_word.arg_index;
   assign rsp_store_offset = rsp_word.store_offset;
   assign rsp_arg_count    = rsp_word.arg_count;
   assign rsp_status       = rsp_word.status;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the quoted word splitter core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qws_pkg::*;

   localparam int MAX_ARGS     = 16;
   localparam int STORE_BYTES  = 2048;
   localparam int ITEMS        = 1200;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;

   typedef logic [DATA_W-1:0] char_type;

   // Tracks the splitter state word by word and keeps the response words
   // that each accepted byte is due to produce, oldest first.
   class arg_split_tracker;
      mode_type    mode;
      quote_type   quote;
      int unsigned args_started;
      int unsigned bytes_used;
      status_type  err;
      result_type  due_words[$];
      int unsigned failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         mode         = MODE_BETWEEN;
         quote        = QUOTE_NONE;
         args_started = 0;
         bytes_used   = 0;
         err          = STATUS_OK;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void due(kind_type kind, char_type data, int unsigned idx, int unsigned off,
                        int unsigned cnt, status_type st);
         result_type r;
         r.kind         = kind;
         r.data_byte    = data;
         r.arg_index    = idx[INDEX_W-1:0];
         r.store_offset = off[OFFSET_W-1:0];
         r.arg_count    = cnt[COUNT_W-1:0];
         r.status       = st;
         due_words.push_back(r);
      endfunction

      // One slot always stays free for the terminator of the open argument.
      function bit room_left();
         return bytes_used + 2 <= STORE_BYTES;
      endfunction

      function void keep(char_type ch);
         if (!room_left()) begin
            err = STATUS_BIG;
            return;
         end
         due(KIND_BYTE, ch, args_started - 1, bytes_used, 0, STATUS_OK);
         bytes_used++;
      endfunction

      function void take_byte(char_type ch);
         bit        blank;
         quote_type q;
         status_type st;
         blank = (ch == CH_SPACE) || (ch == CH_TAB);
         if (ch == CH_NUL) begin
            st = err;
            if (st == STATUS_OK) begin
               if (mode == MODE_ESCAPE || (mode == MODE_IN_ARG && quote != QUOTE_NONE)) begin
                  st = STATUS_INVALID;
               end else if (mode == MODE_IN_ARG) begin
                  due(KIND_ARG_END, '0, args_started - 1, bytes_used, 0, STATUS_OK);
                  bytes_used++;
               end
            end
            due(KIND_CMD_END, '0, 0, bytes_used, args_started, st);
            clear();
            return;
         end
         if (err != STATUS_OK) return;
         if (mode == MODE_ESCAPE) begin
            mode = MODE_IN_ARG;
            keep(ch);
            return;
         end
         if (mode == MODE_BETWEEN) begin
            if (blank) return;
            if (args_started >= MAX_ARGS || !room_left()) begin
               err = STATUS_BIG;
               return;
            end
            args_started++;
            mode  = MODE_IN_ARG;
            quote = QUOTE_NONE;
         end
         if (quote == QUOTE_NONE && blank) begin
            due(KIND_ARG_END, '0, args_started - 1, bytes_used, 0, STATUS_OK);
            bytes_used++;
            mode = MODE_BETWEEN;
            return;
         end
         if (ch == CH_BACKSLASH && quote != QUOTE_SINGLE) begin
            mode = MODE_ESCAPE;
            return;
         end
         if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
            q = (ch == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
            if (quote == QUOTE_NONE) begin
               quote = q;
               return;
            end
            if (quote == q) begin
               quote = QUOTE_NONE;
               return;
            end
         end
         keep(ch);
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (due_words.size() == 0) begin
            if (failures < 10)
               $display("unexpected word: kind %0d byte %02h arg %0d offset %0d count %0d status %0d",
                        got.kind, got.data_byte, got.arg_index, got.store_offset,
                        got.arg_count, got.status);
            failures++;
            return;
         end
         want = due_words.pop_front();
         if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
             got.arg_index !== want.arg_index || got.store_offset !== want.store_offset ||
             got.arg_count !== want.arg_count || got.status !== want.status) begin
            if (failures < 10) begin
               $display("mismatch: expected kind %0d byte %02h arg %0d offset %0d count %0d status %0d",
                        want.kind, want.data_byte, want.arg_index, want.store_offset,
                        want.arg_count, want.status);
               $display("          actual   kind %0d byte %02h arg %0d offset %0d count %0d status %0d",
                        got.kind, got.data_byte, got.arg_index, got.store_offset,
                        got.arg_count, got.status);
            end
            failures++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [DATA_W-1:0]   req_ch    = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [DATA_W-1:0]   rsp_data_byte;
   logic [INDEX_W-1:0]  rsp_arg_index;
   logic [OFFSET_W-1:0] rsp_store_offset;
   logic [COUNT_W-1:0]  rsp_arg_count;
   logic [STATUS_W-1:0] rsp_status;

   arg_split_tracker board;

   // When eager is set, neither side idles between words; hold_cycles asks
   // the receiver for one long stall, counted in its own process.
   bit eager       = 1'b0;
   int hold_cycles = 0;

   quoted_word_splitter_core #(
      .MAX_ARGS    (MAX_ARGS),
      .STORE_BYTES (STORE_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_arg_index    (rsp_arg_index),
      .rsp_store_offset (rsp_store_offset),
      .rsp_arg_count    (rsp_arg_count),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Byte generators. Plain bytes never separate, quote or escape; any_char
   // leans toward the bytes that the splitter treats specially.
   function automatic char_type plain_char();
      char_type c;
      do c = char_type'($urandom_range(1, 255));
      while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
             c == CH_BACKSLASH);
      return c;
   endfunction

   function automatic char_type any_char();
      case ($urandom_range(0, 9))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_SQUOTE;
         3: return CH_DQUOTE;
         4: return CH_BACKSLASH;
         default: return char_type'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic char_type blank_char();
      return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
   endfunction

   // One well-formed argument built from plain runs, quoted groups and
   // escaped bytes. An empty quoted group gives an empty argument.
   function automatic void add_arg(ref char_type line[$]);
      int       segs;
      int       n;
      char_type c;
      segs = $urandom_range(1, 3);
      for (int seg = 0; seg < segs; seg++) begin
         n = $urandom_range(0, 5);
         case ($urandom_range(0, 3))
            0: repeat (n + 1) line.push_back(plain_char());
            1: begin
               line.push_back(CH_SQUOTE);
               repeat (n) begin
                  do c = any_char(); while (c == CH_SQUOTE);
                  line.push_back(c);
               end
               line.push_back(CH_SQUOTE);
            end
            2: begin
               line.push_back(CH_DQUOTE);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) begin
                     line.push_back(CH_BACKSLASH);
                     line.push_back(any_char());
                  end else begin
                     do c = any_char(); while (c == CH_DQUOTE || c == CH_BACKSLASH);
                     line.push_back(c);
                  end
               end
               line.push_back(CH_DQUOTE);
            end
            default: begin
               line.push_back(CH_BACKSLASH);
               line.push_back(any_char());
            end
         endcase
      end
   endfunction

   // Mostly well-formed commands, some with an open quote or a trailing
   // backslash, some pure noise. Now and then more arguments than allowed.
   function automatic void make_command(ref char_type line[$]);
      int pick;
      int nargs;
      line.delete();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) line.push_back(blank_char());
         for (int a = 0; a < nargs; a++) begin
            add_arg(line);
            if (a < nargs - 1 || $urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) line.push_back(blank_char());
         end
         if (pick >= 70) begin
            case ($urandom_range(0, 2))
               0: begin
                  line.push_back(CH_SQUOTE);
                  line.push_back(plain_char());
               end
               1: begin
                  line.push_back(CH_DQUOTE);
                  line.push_back(plain_char());
               end
               default: line.push_back(CH_BACKSLASH);
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 15)) line.push_back(any_char());
      end
      line.push_back(CH_NUL);
   endfunction

   // Offers one byte after a random gap and holds it until the block takes
   // it. The tracker sees the byte only once the handshake completes.
   task automatic send_word(char_type ch);
      int gap;
      gap = eager ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= ch;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_byte(ch);
   endtask

   task automatic send_line(char_type line[$]);
      foreach (line[i]) send_word(line[i]);
   endtask

   task automatic send_text(string text);
      for (int i = 0; i < text.len(); i++) send_word(char_type'(text[i]));
   endtask

   // Drops valid and waits for every due word to come back. At least one
   // edge passes so that valid is never lowered and raised in one step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Response side: stalls a random number of cycles before each word, or
   // for one long stretch when asked, then takes the word and checks it.
   initial begin
      int         gap;
      result_type got;
      wait (reset == 1'b0);
      forever begin
         if (hold_cycles > 0) begin
            gap         = hold_cycles;
            hold_cycles = 0;
         end else begin
            gap = eager ? 0 : $urandom_range(0, 19);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.kind         = kind_type'(rsp_kind);
         got.data_byte    = rsp_data_byte;
         got.arg_index    = rsp_arg_index;
         got.store_offset = rsp_store_offset;
         got.arg_count    = rsp_arg_count;
         got.status       = status_type'(rsp_status);
         board.check_word(got);
      end
   end

   // Watchdog: a hung handshake or a lost word ends the run here.
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      char_type line[$];
      int       random_items;
      int       cmd_no;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed commands. The first separates by tab and space, puts a
      // double quote inside single quotes, escapes a blank and keeps 0xFF.
      send_text("a\t'x\"y' \\ ");
      send_word(8'hFF);
      send_word(CH_NUL);
      // A double quote left open at the end of the command.
      send_text("\"q");
      send_word(CH_NUL);
      // A trailing backslash.
      send_text("\\");
      send_word(CH_NUL);
      // A backslash inside single quotes is kept as is, next to byte 0x01.
      send_text("'\\'");
      send_word(8'h01);
      send_word(CH_NUL);
      // An escaped double quote inside double quotes.
      send_text("\"\\\"\"");
      send_word(CH_NUL);
      wait_drained();

      random_items = 0;
      cmd_no       = 0;
      while (random_items < ITEMS) begin
         eager = ($urandom_range(0, 3) == 0);
         case (cmd_no)
            10: begin
               // The receiver holds off while the sender keeps offering, so
               // the queue fills and the block stalls its input.
               line.delete();
               repeat (40) line.push_back(plain_char());
               line.push_back(CH_NUL);
               eager       = 1'b1;
               hold_cycles = HOLD_CYCLES;
            end
            default: begin
               make_command(line);
            end
         endcase
         send_line(line);
         random_items += line.size();
         if (cmd_no % 16 == 15) wait_drained();
         cmd_no++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/qws_pkg.sv
design/qws_front.sv
design/qws_queue.sv
design/qws_back.sv
design/quoted_word_splitter_core.sv
sim/testbench.sv
